// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gtp_pkg.sv =====
package gtp_pkg;

	// cosine format
	localparam int COSINE_FRAC_BITS = 30;
	localparam int OUT_FRAC = 24;
	localparam logic signed [31:0] COS_ONE = 32'sd1 <<< COSINE_FRAC_BITS;

	// near limit register
	localparam logic [19:0] LIMIT_RESET = 20'd1074;

	// outcome codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FAR = 2'd1;
	localparam logic [1:0] ST_NEAR_ANTI = 2'd2;
	localparam logic [1:0] ST_ANTI_FAR = 2'd3;

	// chain lengths
	localparam int ROOT_CELLS = 31;
	localparam int DIV_CELLS = 48;

	// output saturation
	localparam logic [47:0] OUT_POS_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] OUT_NEG_MAG = 48'h8000_0000_0000;

	// item travelling through the square root cells
	typedef struct packed {
		logic [61:0] rad;
		logic [35:0] rem;
		logic [30:0] root;
		logic signed [32:0] d_fl;
		logic signed [62:0] num_xi;
		logic signed [63:0] num_eta;
		logic [1:0] status;
	} root_t;

	// item travelling through the divider cells
	typedef struct packed {
		logic [62:0] dm;
		logic [47:0] nsh_x;
		logic [47:0] nsh_e;
		logic [62:0] rem_x;
		logic [62:0] rem_e;
		logic [47:0] q_x;
		logic [47:0] q_e;
		logic ovf_x;
		logic ovf_e;
		logic neg_x;
		logic neg_e;
		logic [1:0] status;
	} div_t;

endpackage

// ===== rtl/gtp_root_cell.sv =====
module gtp_root_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_in,
	input  gtp_pkg::root_t   d_in,
	output logic             valid_out,
	output gtp_pkg::root_t   d_out
);

	logic [35:0] trial;
	gtp_pkg::root_t nxt;

	// one result bit per cell: try (root*4+1) against the remainder
	always_comb begin
		trial = {d_in.rem[33:0], d_in.rad[61:60]} - {3'b000, d_in.root, 2'b01};
		nxt = d_in;
		nxt.rad = {d_in.rad[59:0], 2'b00};
		if (!trial[35]) begin
			nxt.rem = trial;
			nxt.root = {d_in.root[29:0], 1'b1};
		end else begin
			nxt.rem = {d_in.rem[33:0], d_in.rad[61:60]};
			nxt.root = {d_in.root[29:0], 1'b0};
		end
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

// ===== rtl/gtp_div_cell.sv =====
module gtp_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  gtp_pkg::div_t   d_in,
	output logic            valid_out,
	output gtp_pkg::div_t   d_out
);

	logic [63:0] trial_x;
	logic [63:0] trial_e;
	logic [63:0] diff_x;
	logic [63:0] diff_e;
	logic ge_x;
	logic ge_e;
	gtp_pkg::div_t nxt;

	// one restoring step for each lane
	always_comb begin
		trial_x = {d_in.rem_x, d_in.nsh_x[47]};
		trial_e = {d_in.rem_e, d_in.nsh_e[47]};
		diff_x = trial_x - {1'b0, d_in.dm};
		diff_e = trial_e - {1'b0, d_in.dm};
		ge_x = trial_x >= {1'b0, d_in.dm};
		ge_e = trial_e >= {1'b0, d_in.dm};
		nxt = d_in;
		nxt.nsh_x = {d_in.nsh_x[46:0], 1'b0};
		nxt.nsh_e = {d_in.nsh_e[46:0], 1'b0};
		nxt.rem_x = ge_x ? diff_x[62:0] : trial_x[62:0];
		nxt.rem_e = ge_e ? diff_e[62:0] : trial_e[62:0];
		nxt.q_x = {d_in.q_x[46:0], ge_x};
		nxt.q_e = {d_in.q_e[46:0], ge_e};
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

// ===== rtl/gnomonic_tangent_plane_projection.sv =====
// Gnomonic projection of a star direction onto the tangent plane at a centre direction.
// One item is taken every cycle while in_stall is low. Its path to the output register is the
// registered stages of products and sums, a row of 31 square root cells (one root bit each),
// registers for the denominator product and its magnitude, and a row of 48 divider cells. Each
// divider cell produces one quotient bit of xi and one of eta. A stalled result sits in the
// output register and one more item in a skid register. in_stall rises only while that skid
// register is full, and then the whole row of cells holds.
`include "assert_macros.svh"

module gnomonic_tangent_plane_projection (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [19:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  star_x,
	input  logic signed [31:0]  star_y,
	input  logic signed [31:0]  star_z,
	input  logic signed [31:0]  center_x,
	input  logic signed [31:0]  center_y,
	input  logic signed [31:0]  center_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [47:0]  plane_xi,
	output logic signed [47:0]  plane_eta,
	output logic [1:0]          outcome
);

	function automatic logic signed [31:0] sat_cos(input logic signed [31:0] v);
		logic signed [31:0] r;
		r = v;
		if (v > gtp_pkg::COS_ONE) r = gtp_pkg::COS_ONE;
		if (v < -gtp_pkg::COS_ONE) r = -gtp_pkg::COS_ONE;
		return r;
	endfunction

	function automatic logic signed [61:0] mul_cos(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p[61:0];
	endfunction

	function automatic logic [47:0] sat_out(input logic [47:0] q, input logic ovf,
		input logic neg);
		logic [47:0] m;
		if (neg) begin
			m = (ovf || q > gtp_pkg::OUT_NEG_MAG) ? gtp_pkg::OUT_NEG_MAG : q;
			return 48'd0 - m;
		end
		return (ovf || q > gtp_pkg::OUT_POS_MAX) ? gtp_pkg::OUT_POS_MAX : q;
	endfunction

	logic en;
	logic [19:0] lim_q;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= gtp_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			lim_q <= cfg_data;
		end
	end

	// stage 1: saturate inputs, form all cosine products
	logic signed [31:0] xs, ys, zs, x0s, y0s, z0s, x0e;
	logic valid_s1;
	logic signed [61:0] p_x0x0_s1, p_y0y0_s1, p_xx0_s1, p_yy0_s1, p_zz0_s1;
	logic signed [61:0] p_yx0_s1, p_xy0_s1;
	logic signed [31:0] z_s1, z0_s1;

	always_comb begin
		xs = sat_cos(star_x);
		ys = sat_cos(star_y);
		zs = sat_cos(star_z);
		x0s = sat_cos(center_x);
		y0s = sat_cos(center_y);
		z0s = sat_cos(center_z);
		// tangent point at a pole: x0 taken as one lsb
		x0e = (x0s == 32'sd0 && y0s == 32'sd0) ? 32'sd1 : x0s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_x0x0_s1 <= mul_cos(x0s, x0s);
			p_y0y0_s1 <= mul_cos(y0s, y0s);
			p_xx0_s1 <= mul_cos(xs, x0e);
			p_yy0_s1 <= mul_cos(ys, y0s);
			p_zz0_s1 <= mul_cos(zs, z0s);
			p_yx0_s1 <= mul_cos(ys, x0e);
			p_xy0_s1 <= mul_cos(xs, y0s);
			z_s1 <= zs;
			z0_s1 <= z0s;
		end
	end

	// stage 2: sums, classify the denominator, floor to cosine scale
	logic [19:0] lim_eff;
	logic signed [62:0] lim2, r2, w, d, dc, num_xi, dsh, r2sh, wsh;
	logic [1:0] st;
	logic valid_s2;
	logic [61:0] r2_s2;
	logic signed [32:0] d_fl_s2, wf_s2;
	logic [31:0] r2f_s2;
	logic signed [62:0] num_xi_s2;
	logic [1:0] status_s2;
	logic signed [31:0] z_s2, z0_s2;

	always_comb begin
		lim_eff = (lim_q == 20'd0) ? 20'd1 : lim_q;
		lim2 = $signed(63'(lim_eff)) <<< gtp_pkg::COSINE_FRAC_BITS;
		r2 = 63'(p_x0x0_s1) + 63'(p_y0y0_s1);
		w = 63'(p_xx0_s1) + 63'(p_yy0_s1);
		d = w + 63'(p_zz0_s1);
		num_xi = 63'(p_yx0_s1) - 63'(p_xy0_s1);
		dc = d;
		if (d > lim2) begin
			st = gtp_pkg::ST_OK;
		end else if (d >= 63'sd0) begin
			st = gtp_pkg::ST_FAR;
			dc = lim2;
		end else if (d > -lim2) begin
			st = gtp_pkg::ST_NEAR_ANTI;
			dc = -lim2;
		end else begin
			st = gtp_pkg::ST_ANTI_FAR;
		end
		dsh = dc >>> gtp_pkg::COSINE_FRAC_BITS;
		r2sh = r2 >>> gtp_pkg::COSINE_FRAC_BITS;
		wsh = w >>> gtp_pkg::COSINE_FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s2 <= r2[61:0];
			d_fl_s2 <= dsh[32:0];
			r2f_s2 <= r2sh[31:0];
			wf_s2 <= wsh[32:0];
			num_xi_s2 <= num_xi;
			status_s2 <= st;
			z_s2 <= z_s1;
			z0_s2 <= z0_s1;
		end
	end

	// stage 3: eta numerator products
	logic signed [64:0] pz_full, pw_full;
	logic valid_s3;
	logic signed [63:0] pz_s3, pw_s3;
	logic [61:0] r2_s3;
	logic signed [32:0] d_fl_s3;
	logic signed [62:0] num_xi_s3;
	logic [1:0] status_s3;

	always_comb begin
		pz_full = z_s2 * $signed({1'b0, r2f_s2});
		pw_full = z0_s2 * wf_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pz_s3 <= pz_full[63:0];
			pw_s3 <= pw_full[63:0];
			r2_s3 <= r2_s2;
			d_fl_s3 <= d_fl_s2;
			num_xi_s3 <= num_xi_s2;
			status_s3 <= status_s2;
		end
	end

	// square root row
	gtp_pkg::root_t root_d [0:gtp_pkg::ROOT_CELLS];
	logic root_v [0:gtp_pkg::ROOT_CELLS];

	always_comb begin
		root_v[0] = valid_s3;
		root_d[0].rad = r2_s3;
		root_d[0].rem = 36'd0;
		root_d[0].root = 31'd0;
		root_d[0].d_fl = d_fl_s3;
		root_d[0].num_xi = num_xi_s3;
		root_d[0].num_eta = pz_s3 - pw_s3;
		root_d[0].status = status_s3;
	end

	for (genvar i = 0; i < gtp_pkg::ROOT_CELLS; i++) begin : g_root
		gtp_root_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (root_v[i]),
			.d_in      (root_d[i]),
			.valid_out (root_v[i+1]),
			.d_out     (root_d[i+1])
		);
	end

	// stage 5: denominator d * r
	gtp_pkg::root_t rt;
	logic [30:0] r_eff;
	logic signed [64:0] den_full;
	logic valid_s5;
	logic signed [63:0] den_s5, num_eta_s5;
	logic signed [62:0] num_xi_s5;
	logic [1:0] status_s5;

	always_comb begin
		rt = root_d[gtp_pkg::ROOT_CELLS];
		r_eff = (rt.root == 31'd0) ? 31'd1 : rt.root;
		den_full = rt.d_fl * $signed({1'b0, r_eff});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= root_v[gtp_pkg::ROOT_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s5 <= den_full[63:0];
			num_xi_s5 <= rt.num_xi;
			num_eta_s5 <= rt.num_eta;
			status_s5 <= rt.status;
		end
	end

	// stage 6: magnitudes and quotient signs
	logic [63:0] den_abs, ne_abs;
	logic [62:0] nx_abs;
	logic valid_s6;
	logic [62:0] dm_s6, nx_s6, ne_s6;
	logic neg_x_s6, neg_e_s6;
	logic [1:0] status_s6;

	always_comb begin
		den_abs = den_s5[63] ? -den_s5 : den_s5;
		nx_abs = num_xi_s5[62] ? -num_xi_s5 : num_xi_s5;
		ne_abs = num_eta_s5[63] ? -num_eta_s5 : num_eta_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dm_s6 <= (den_abs == 64'd0) ? 63'd1 : den_abs[62:0];
			nx_s6 <= nx_abs;
			ne_s6 <= ne_abs[62:0];
			neg_x_s6 <= num_xi_s5[62] ^ den_s5[63];
			neg_e_s6 <= num_eta_s5[63] ^ den_s5[63];
			status_s6 <= status_s5;
		end
	end

	// divider row: quotient bits above the output width are settled up front
	gtp_pkg::div_t div_d [0:gtp_pkg::DIV_CELLS];
	logic div_v [0:gtp_pkg::DIV_CELLS];
	logic [62:0] hx, he;
	logic ovx, ove;

	always_comb begin
		hx = nx_s6 >> gtp_pkg::OUT_FRAC;
		he = ne_s6 >> gtp_pkg::OUT_FRAC;
		ovx = hx >= dm_s6;
		ove = he >= dm_s6;
		div_v[0] = valid_s6;
		div_d[0].dm = dm_s6;
		div_d[0].nsh_x = {nx_s6[23:0], 24'd0};
		div_d[0].nsh_e = {ne_s6[23:0], 24'd0};
		div_d[0].rem_x = ovx ? 63'd0 : hx;
		div_d[0].rem_e = ove ? 63'd0 : he;
		div_d[0].q_x = 48'd0;
		div_d[0].q_e = 48'd0;
		div_d[0].ovf_x = ovx;
		div_d[0].ovf_e = ove;
		div_d[0].neg_x = neg_x_s6;
		div_d[0].neg_e = neg_e_s6;
		div_d[0].status = status_s6;
	end

	for (genvar j = 0; j < gtp_pkg::DIV_CELLS; j++) begin : g_div
		gtp_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (div_v[j]),
			.d_in      (div_d[j]),
			.valid_out (div_v[j+1]),
			.d_out     (div_d[j+1])
		);
	end

	// output register and skid entry
	gtp_pkg::div_t dq;
	logic p_valid;
	logic [47:0] p_xi, p_eta;
	logic out_valid_q, skid_valid_q;
	logic [47:0] out_xi_q, out_eta_q, skid_xi_q, skid_eta_q;
	logic [1:0] out_st_q, skid_st_q;
	logic out_free;

	always_comb begin
		dq = div_d[gtp_pkg::DIV_CELLS];
		p_valid = div_v[gtp_pkg::DIV_CELLS];
		p_xi = sat_out(dq.q_x, dq.ovf_x, dq.neg_x);
		p_eta = sat_out(dq.q_e, dq.ovf_e, dq.neg_e);
		out_free = !out_valid_q || !out_stall;
	end

	assign en = !skid_valid_q;
	assign in_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (out_free) begin
			out_valid_q <= p_valid;
		end else if (p_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_xi_q <= skid_xi_q;
				out_eta_q <= skid_eta_q;
				out_st_q <= skid_st_q;
			end
		end else if (out_free) begin
			out_xi_q <= p_xi;
			out_eta_q <= p_eta;
			out_st_q <= dq.status;
		end else begin
			skid_xi_q <= p_xi;
			skid_eta_q <= p_eta;
			skid_st_q <= dq.status;
		end
	end

	assign out_valid = out_valid_q;
	assign plane_xi = out_xi_q;
	assign plane_eta = out_eta_q;
	assign outcome = out_st_q;

	// checks
	`ASSERT_ALWAYS(a_skid_behind_out, clk, arst_n, !skid_valid_q || out_valid_q, "orphan skid")
	`ASSERT_NEXT(a_skid_kept, clk, arst_n, skid_valid_q && out_stall, skid_valid_q, "skid lost")
	`ASSERT_NEXT(a_cfg_taken, clk, arst_n, cfg_valid, lim_q == $past(cfg_data), "write lost")

endmodule
